/* hdl/hmmf_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants, log-domain arithmetic and correction table of the HMM forward block.
package hmmf_pkg;

	localparam int LSE_TABLE_DEPTH = 256;
	localparam int LOG_FRAC_BITS   = 12;
	localparam int LSE_INDEX_SHIFT = 7;
	localparam int LSE_IDX_W       = $clog2(LSE_TABLE_DEPTH);
	localparam int LSE_VAL_W       = LOG_FRAC_BITS;
	localparam int ACC_W           = 32;
	localparam int FIELD_W         = 16;
	localparam int CFG_W           = 64;

	localparam logic [FIELD_W-1:0] LOG_ZERO_RAW = 16'h8000;
	localparam logic signed [ACC_W-1:0] ACC_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		REG_LOG_INITIAL     = 2'd0,
		REG_LOG_TRANSITION  = 2'd1,
		REG_LOG_EMISSION_AT = 2'd2,
		REG_LOG_EMISSION_GC = 2'd3
	} cfg_reg_t;

	// Log accumulator with its log-zero flag
	typedef struct packed {
		logic signed [ACC_W-1:0] val;
		logic                    zero;
	} log_acc_t;

	typedef struct packed {
		log_acc_t acc;
		logic     sat;
	} acc_sat_t;

	typedef struct packed {
		log_acc_t [1:0] alpha;
		logic           sat;
	} trellis_out_t;

	typedef logic [LSE_VAL_W-1:0] lse_rom_t [LSE_TABLE_DEPTH];

	// Long division by shift and subtract, elaboration only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [64:0] r;
		logic [63:0] q;
		r = '0;
		q = '0;
		for (int i = 63; i >= 0; i--) begin
			r = {r[63:0], n[i]};
			if (r >= {1'b0, d}) begin
				r = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// ln(1 + e^-x) in Q(LOG_FRAC_BITS), x = i * 2^LSE_INDEX_SHIFT / 2^LOG_FRAC_BITS
	function automatic lse_rom_t build_lse_rom();
		lse_rom_t    rom;
		logic [63:0] one;
		logic [63:0] step;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] ratio;
		logic [63:0] e;
		logic [63:0] z;
		logic [63:0] z2;
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] rnd;
		one  = 64'd1 << 30;
		step = 64'd1 << (30 + LSE_INDEX_SHIFT - LOG_FRAC_BITS);
		term = one;
		pos  = one;
		neg  = '0;
		e    = one;
		rnd  = 64'd1 << (29 - LOG_FRAC_BITS);
		for (int k = 1; k <= 20; k++) begin
			term = udiv64((term * step) >> 30, 64'(k));
			if (k % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		ratio = pos - neg;
		for (int i = 0; i < LSE_TABLE_DEPTH; i++) begin
			z   = udiv64(e << 30, 2 * one + e);
			z2  = (z * z) >> 30;
			p   = z;
			sum = '0;
			for (int k = 0; k < 16; k++) begin
				sum = sum + udiv64(p, 64'(2 * k + 1));
				p   = (p * z2) >> 30;
			end
			sum = sum * 2;
			rom[i] = LSE_VAL_W'((sum + rnd) >> (30 - LOG_FRAC_BITS));
			e = (e * ratio + (one >> 1)) >> 30;
		end
		return rom;
	endfunction

	localparam lse_rom_t LSE_ROM = build_lse_rom();

	function automatic logic signed [ACC_W-1:0] sext_field(input logic [FIELD_W-1:0] raw);
		return {{(ACC_W-FIELD_W){raw[FIELD_W-1]}}, raw};
	endfunction

	// Saturating signed add; sat marks a clamp
	function automatic acc_sat_t sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [ACC_W-1:0] b);
		logic signed [ACC_W:0] s;
		acc_sat_t              r;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		r.acc.zero = 1'b0;
		r.sat      = 1'b0;
		r.acc.val  = s[ACC_W-1:0];
		if (s[ACC_W] != s[ACC_W-1]) begin
			r.sat     = 1'b1;
			r.acc.val = s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return r;
	endfunction

	// Add a 16-bit log field to an accumulator; log zero absorbs
	function automatic acc_sat_t add_field(input log_acc_t a, input logic [FIELD_W-1:0] raw);
		acc_sat_t r;
		if (a.zero || raw == LOG_ZERO_RAW) begin
			r.acc.val  = '0;
			r.acc.zero = 1'b1;
			r.sat      = 1'b0;
		end else begin
			r = sat_add(a.val, sext_field(raw));
		end
		return r;
	endfunction

endpackage

/* hdl/hmmf_lse.sv */
`timescale 1ns / 1ps
// Log-sum-exp of two log accumulators: max plus table correction, saturating.
module hmmf_lse import hmmf_pkg::*; (
	input  log_acc_t a,
	input  log_acc_t b,
	output acc_sat_t r
);

	logic signed [ACC_W-1:0] hi;
	logic signed [ACC_W-1:0] lo;
	logic [ACC_W:0]          diff;
	logic [ACC_W:0]          idx_full;
	logic [LSE_IDX_W-1:0]    idx;
	logic [ACC_W-1:0]        corr;

	always_comb begin
		hi       = (a.val > b.val) ? a.val : b.val;
		lo       = (a.val > b.val) ? b.val : a.val;
		diff     = {hi[ACC_W-1], hi} - {lo[ACC_W-1], lo};
		idx_full = diff >> LSE_INDEX_SHIFT;
		// clamp to the last table entry
		if (idx_full > (ACC_W+1)'(LSE_TABLE_DEPTH - 1))
			idx = LSE_IDX_W'(LSE_TABLE_DEPTH - 1);
		else
			idx = idx_full[LSE_IDX_W-1:0];
		corr = ACC_W'(LSE_ROM[idx]);

		if (a.zero && b.zero) begin
			r.acc.val  = '0;
			r.acc.zero = 1'b1;
			r.sat      = 1'b0;
		end else if (a.zero) begin
			r.acc = b;
			r.sat = 1'b0;
		end else if (b.zero) begin
			r.acc = a;
			r.sat = 1'b0;
		end else begin
			r = sat_add(hi, signed'(corr));
		end
	end

endmodule

/* hdl/hmmf_trellis.sv */
`timescale 1ns / 1ps
// One forward step of the two-state trellis: initialization or recursion for one base.
module hmmf_trellis import hmmf_pkg::*; (
	input  log_acc_t [1:0]     alpha,
	input  logic [1:0]         base,
	input  logic               first,
	input  logic [31:0]        log_initial,
	input  logic [CFG_W-1:0]   log_transition,
	input  logic [CFG_W-1:0]   log_emission_at,
	input  logic [CFG_W-1:0]   log_emission_gc,
	output trellis_out_t       nxt
);

	logic [5:0] emit_sel;

	assign emit_sel = {base, 4'd0};

	for (genvar j = 0; j < 2; j++) begin : g_state
		logic [FIELD_W-1:0] emit_raw;
		logic [FIELD_W-1:0] init_raw;
		log_acc_t           init_acc;
		acc_sat_t           init_r;
		acc_sat_t           p0;
		acc_sat_t           p1;
		acc_sat_t           merged;
		acc_sat_t           rec_r;

		assign emit_raw = (j == 0) ? log_emission_at[emit_sel +: FIELD_W]
		                           : log_emission_gc[emit_sel +: FIELD_W];
		assign init_raw = log_initial[FIELD_W*j +: FIELD_W];

		always_comb begin
			init_acc.val  = sext_field(init_raw);
			init_acc.zero = (init_raw == LOG_ZERO_RAW);
			init_r        = add_field(init_acc, emit_raw);
			p0 = add_field(alpha[0], log_transition[FIELD_W*j +: FIELD_W]);
			p1 = add_field(alpha[1], log_transition[FIELD_W*(2+j) +: FIELD_W]);
		end

		hmmf_lse u_lse (
			.a (p0.acc),
			.b (p1.acc),
			.r (merged)
		);

		assign rec_r = add_field(merged.acc, emit_raw);
	end

	always_comb begin
		if (first) begin
			nxt.alpha[0] = g_state[0].init_r.acc;
			nxt.alpha[1] = g_state[1].init_r.acc;
			nxt.sat      = g_state[0].init_r.sat | g_state[1].init_r.sat;
		end else begin
			nxt.alpha[0] = g_state[0].rec_r.acc;
			nxt.alpha[1] = g_state[1].rec_r.acc;
			nxt.sat      = g_state[0].p0.sat | g_state[0].p1.sat | g_state[0].merged.sat |
			               g_state[0].rec_r.sat | g_state[1].p0.sat | g_state[1].p1.sat |
			               g_state[1].merged.sat | g_state[1].rec_r.sat;
		end
	end

endmodule

/* hdl/hmm_forward_log_likelihood.sv */
`timescale 1ns / 1ps
// Top level of the two-state HMM forward log-likelihood engine.
//
// Streams DNA bases (G=0, C=1, A=2, T=3) through the forward recursion of a
// two-state (AT-rich, GC-rich) hidden Markov model in the log domain. Log values
// are signed Q.12 with a separate log-zero flag; the 16-bit register pattern
// 0x8000 means log zero. A base tagged first loads each state with initial plus
// emission; every other base adds transitions, merges both paths with a
// log-sum-exp (max plus a 256-entry ln(1+e^-d) table indexed by d>>7) and adds
// the emission. A base tagged last yields one result beat: the log-sum of both
// states, a zero-likelihood flag, and a sticky saturation flag for the sequence.
// Rate: one base per clock, sustained, unless a last base waits on a stalled
// result side. The alpha update (transition add, log-sum-exp with table lookup,
// emission add) is combinational around the alpha registers, so that loop sets
// the rate. The result beat passes the input register, snapshot stage and result
// register; the final log-sum runs in the snapshot stage, off the recursion loop.
// The user writes configuration through the plain write port only while the block
// is idle; the block does not enforce it. There is no clearing pass after reset.
module hmm_forward_log_likelihood import hmmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	// base channel
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         base,
	input  logic               first,
	input  logic               last,
	// result channel
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [31:0] log_likelihood,
	output logic               likelihood_zero,
	output logic               saturated
);

	// Configuration registers
	logic [31:0]      log_initial_q;
	logic [CFG_W-1:0] log_transition_q;
	logic [CFG_W-1:0] log_emission_at_q;
	logic [CFG_W-1:0] log_emission_gc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_initial_q     <= '0;
			log_transition_q  <= '0;
			log_emission_at_q <= '0;
			log_emission_gc_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_LOG_INITIAL:     log_initial_q     <= cfg_data[31:0];
				REG_LOG_TRANSITION:  log_transition_q  <= cfg_data;
				REG_LOG_EMISSION_AT: log_emission_at_q <= cfg_data;
				REG_LOG_EMISSION_GC: log_emission_gc_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1: input register
	logic       valid_s1;
	logic [1:0] base_s1;
	logic       first_s1;
	logic       last_s1;

	// Recursion state
	log_acc_t [1:0] alpha_q;
	logic           sat_q;

	// Stage 2: snapshot of the states for a last base
	logic           valid_s2;
	log_acc_t [1:0] alpha_s2;
	logic           sat_s2;
	logic           new_s2_q;

	// Result register
	logic                    result_valid_q;
	logic signed [ACC_W-1:0] log_likelihood_q;
	logic                    likelihood_zero_q;
	logic                    saturated_q;

	// Handshake chain
	logic out_ready;
	logic s2_ready;
	logic s2_fire;
	logic s1_fire;
	logic item_accept;

	assign out_ready   = !result_valid_q || !result_stall;
	assign s2_fire     = valid_s2 && out_ready;
	assign s2_ready    = !valid_s2 || out_ready;
	// a base that yields no result never waits on the result side
	assign s1_fire     = valid_s1 && (!last_s1 || s2_ready);
	assign item_stall  = valid_s1 && !s1_fire;
	assign item_accept = item_valid && !item_stall;

	// One trellis step from the current states
	trellis_out_t step;

	hmmf_trellis u_trellis (
		.alpha           (alpha_q),
		.base            (base_s1),
		.first           (first_s1),
		.log_initial     (log_initial_q),
		.log_transition  (log_transition_q),
		.log_emission_at (log_emission_at_q),
		.log_emission_gc (log_emission_gc_q),
		.nxt             (step)
	);

	// Final log-sum of both states
	acc_sat_t final_r;

	hmmf_lse u_final_lse (
		.a (alpha_s2[0]),
		.b (alpha_s2[1]),
		.r (final_r)
	);

	// The final log-sum can saturate too, and that counts for the rest of the
	// sequence. Fold it into the flag in the cycle right after the snapshot;
	// a later first base clears it as usual.
	logic sat_cur;
	logic sat_next;

	assign sat_cur  = sat_q | (new_s2_q & final_r.sat);
	assign sat_next = (first_s1 ? 1'b0 : sat_cur) | step.sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_accept) begin
			base_s1  <= base;
			first_s1 <= first;
			last_s1  <= last;
		end
	end

	// Advance the recursion once per base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q[0].val  <= '0;
			alpha_q[0].zero <= 1'b1;
			alpha_q[1].val  <= '0;
			alpha_q[1].zero <= 1'b1;
			sat_q           <= 1'b0;
		end else begin
			if (s1_fire) begin
				alpha_q <= step.alpha;
			end
			sat_q <= s1_fire ? sat_next : sat_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			new_s2_q <= 1'b0;
		end else begin
			new_s2_q <= s1_fire && last_s1;
			if (s1_fire && last_s1) begin
				valid_s2 <= 1'b1;
			end else if (s2_fire) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire && last_s1) begin
			alpha_s2 <= step.alpha;
			sat_s2   <= sat_next;
		end
	end

	// Result register: hold while stalled, drop after the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (s2_fire) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_fire) begin
			log_likelihood_q  <= final_r.acc.zero ? '0 : final_r.acc.val;
			likelihood_zero_q <= final_r.acc.zero;
			saturated_q       <= sat_s2 | final_r.sat;
		end
	end

	assign result_valid    = result_valid_q;
	assign log_likelihood  = log_likelihood_q;
	assign likelihood_zero = likelihood_zero_q;
	assign saturated       = saturated_q;

endmodule

/* tb/hmm_forward_checker.sv */
`timescale 1ns / 1ps
// Checker for the HMM forward block: predicts each likelihood beat and compares it.
module hmm_forward_checker import hmmf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic [1:0]         base,
	input  logic               first,
	input  logic               last,
	input  logic               result_valid,
	input  logic               result_stall,
	input  logic signed [31:0] log_likelihood,
	input  logic               likelihood_zero,
	input  logic               saturated,
	output int                 fail_count,
	output int                 pending
);

	typedef struct packed {
		logic signed [31:0] val;
		logic               zero;
	} log_val_t;

	typedef struct packed {
		logic signed [31:0] ll;
		logic               lz;
		logic               sat;
	} likelihood_beat_t;

	int unsigned      corr_rom [LSE_TABLE_DEPTH];
	logic [31:0]      init_reg  = '0;
	logic [63:0]      trans_reg = '0;
	logic [63:0]      emis_at   = '0;
	logic [63:0]      emis_gc   = '0;
	log_val_t         alpha [2] = '{'{32'sd0, 1'b1}, '{32'sd0, 1'b1}};
	logic             sat_seen  = 1'b0;
	likelihood_beat_t expected_beats [$];
	int               mismatches = 0;

	// ln(1 + e^-x) table in Q30 integer steps, rounded to the log fraction
	function automatic void fill_corr_rom();
		logic [63:0] one, step, term, pos, neg, ratio, e, z, z2, p, sum;
		one  = 64'd1 << 30;
		step = 64'd1 << (30 + LSE_INDEX_SHIFT - LOG_FRAC_BITS);
		term = one;
		pos  = one;
		neg  = '0;
		e    = one;
		for (int k = 1; k <= 20; k++) begin
			term = ((term * step) >> 30) / 64'(k);
			if (k % 2 == 1)
				neg = neg + term;
			else
				pos = pos + term;
		end
		ratio = pos - neg;
		for (int i = 0; i < LSE_TABLE_DEPTH; i++) begin
			z   = (e << 30) / (2 * one + e);
			z2  = (z * z) >> 30;
			p   = z;
			sum = '0;
			for (int k = 0; k < 16; k++) begin
				sum = sum + p / 64'(2 * k + 1);
				p   = (p * z2) >> 30;
			end
			sum = sum * 2;
			corr_rom[i] = int'((sum + (64'd1 << (29 - LOG_FRAC_BITS))) >> (30 - LOG_FRAC_BITS));
			e = (e * ratio + (one >> 1)) >> 30;
		end
	endfunction

	initial fill_corr_rom();

	function automatic logic signed [31:0] clamp_add(input longint a, input longint b);
		longint s;
		s = a + b;
		if (s > 64'sd2147483647) begin
			sat_seen = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (s < -64'sd2147483648) begin
			sat_seen = 1'b1;
			return 32'sh8000_0000;
		end
		return s[31:0];
	endfunction

	// log zero on either side absorbs the sum
	function automatic log_val_t accumulate(input log_val_t a, input logic [15:0] raw);
		log_val_t r;
		if (a.zero || raw == LOG_ZERO_RAW) begin
			r.val  = '0;
			r.zero = 1'b1;
		end else begin
			r.val  = clamp_add(a.val, $signed(raw));
			r.zero = 1'b0;
		end
		return r;
	endfunction

	function automatic log_val_t merge(input log_val_t a, input log_val_t b);
		log_val_t r;
		longint   hi, lo, idx;
		if (a.zero && b.zero) begin
			r.val  = '0;
			r.zero = 1'b1;
		end else if (a.zero) begin
			r = b;
		end else if (b.zero) begin
			r = a;
		end else begin
			hi  = (a.val > b.val) ? a.val : b.val;
			lo  = (a.val > b.val) ? b.val : a.val;
			idx = (hi - lo) >> LSE_INDEX_SHIFT;
			if (idx > LSE_TABLE_DEPTH - 1)
				idx = LSE_TABLE_DEPTH - 1;
			r.val  = clamp_add(hi, corr_rom[idx]);
			r.zero = 1'b0;
		end
		return r;
	endfunction

	function automatic void advance_forward(input logic [1:0] b, input logic f, input logic l);
		log_val_t         nxt [2];
		log_val_t         seed, p0, p1, m, sum;
		logic [63:0]      emit [2];
		likelihood_beat_t beat;
		emit[0] = emis_at;
		emit[1] = emis_gc;
		if (f) begin
			sat_seen = 1'b0;
			for (int j = 0; j < 2; j++) begin
				seed.val  = $signed(init_reg[16*j +: 16]);
				seed.zero = init_reg[16*j +: 16] == LOG_ZERO_RAW;
				nxt[j]    = accumulate(seed, emit[j][16*b +: 16]);
			end
		end else begin
			for (int j = 0; j < 2; j++) begin
				p0     = accumulate(alpha[0], trans_reg[16*j +: 16]);
				p1     = accumulate(alpha[1], trans_reg[16*(2+j) +: 16]);
				m      = merge(p0, p1);
				nxt[j] = accumulate(m, emit[j][16*b +: 16]);
			end
		end
		alpha[0] = nxt[0];
		alpha[1] = nxt[1];
		if (l) begin
			sum      = merge(alpha[0], alpha[1]);
			beat.ll  = sum.zero ? 32'sd0 : sum.val;
			beat.lz  = sum.zero;
			beat.sat = sat_seen;
			expected_beats = {expected_beats, beat};
		end
	endfunction

	function automatic void check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		likelihood_beat_t want;
		if (!arst_n) begin
			init_reg  = '0;
			trans_reg = '0;
			emis_at   = '0;
			emis_gc   = '0;
			alpha[0]  = '{32'sd0, 1'b1};
			alpha[1]  = '{32'sd0, 1'b1};
			sat_seen  = 1'b0;
			expected_beats.delete();
			pending <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: log_likelihood %0d", log_likelihood);
					mismatches++;
				end else begin
					want = expected_beats.pop_front();
					check_field("log_likelihood", want.ll, log_likelihood);
					check_field("likelihood_zero", want.lz, likelihood_zero);
					check_field("saturated", want.sat, saturated);
				end
			end
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_index))
					REG_LOG_INITIAL:     init_reg  = cfg_data[31:0];
					REG_LOG_TRANSITION:  trans_reg = cfg_data;
					REG_LOG_EMISSION_AT: emis_at   = cfg_data;
					REG_LOG_EMISSION_GC: emis_gc   = cfg_data;
					default: ;
				endcase
			end
			if (item_valid && !item_stall)
				advance_forward(base, first, last);
			pending <= expected_beats.size();
		end
		fail_count <= mismatches;
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the HMM forward log-likelihood block.
module tb import hmmf_pkg::*; ();

	// Natural-log probabilities of the classic AT/GC-island model in Q4.12
	localparam logic [15:0] LN_0P5  = 16'hF4E9; // -2839
	localparam logic [15:0] LN_0P51 = 16'hF53A; // -2758
	localparam logic [15:0] LN_0P49 = 16'hF496; // -2922
	localparam logic [15:0] LN_0P2  = 16'hE640; // -6592
	localparam logic [15:0] LN_0P3  = 16'hECBD; // -4931
	localparam logic [15:0] MOST_POS = 16'h7FFF;
	localparam logic [15:0] MOST_NEG = 16'h8001;

	localparam logic [1:0] BASE_G = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_A = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam int RANDOM_BASES = 2000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [1:0]         cfg_index = REG_LOG_INITIAL;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [1:0]         base = BASE_G;
	logic               first = 1'b0;
	logic               last = 1'b0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	logic signed [31:0] log_likelihood;
	logic               likelihood_zero;
	logic               saturated;

	int   fail_count;
	int   pending;
	int   bases_sent = 0;
	logic quiet = 1'b0;  // when set, neither side idles
	logic took = 1'b0;

	hmm_forward_log_likelihood dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.base           (base),
		.first          (first),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.log_likelihood (log_likelihood),
		.likelihood_zero(likelihood_zero),
		.saturated      (saturated)
	);

	hmm_forward_checker forward_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.base           (base),
		.first          (first),
		.last           (last),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.log_likelihood (log_likelihood),
		.likelihood_zero(likelihood_zero),
		.saturated      (saturated),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake hangs
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic int draw_wait();
		return quiet ? 0 : $urandom_range(0, 15);
	endfunction

	// Result side: hold off each beat for a random number of cycles once it shows up
	always @(posedge clk) took <= result_valid && !result_stall;

	initial begin
		int hold;
		hold = draw_wait();
		forever begin
			@(negedge clk);
			if (took)
				hold = draw_wait();
			result_stall <= result_valid && hold != 0;
			if (result_valid && hold != 0)
				hold--;
		end
	end

	// Present one base after a random gap and hold it until the block takes it.
	// Valid stays high afterwards so a back-to-back beat needs only one update.
	task automatic send_base(input logic [1:0] b, input logic f, input logic l);
		int gap;
		gap = draw_wait();
		repeat (gap) begin
			@(negedge clk);
			item_valid <= 1'b0;
		end
		@(negedge clk);
		item_valid <= 1'b1;
		base       <= b;
		first      <= f;
		last       <= l;
		do @(posedge clk); while (item_stall);
		bases_sent++;
	endtask

	// Drop valid, wait for every predicted beat, then let the pipeline run dry
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending == 0);
		repeat (6) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
	endtask

	// Load the whole model; only call while the block is idle
	task automatic program_hmm(input logic [31:0] init, input logic [63:0] trans,
			input logic [63:0] at, input logic [63:0] gc);
		write_reg(REG_LOG_INITIAL, {32'($urandom), init}); // upper half is don't-care
		write_reg(REG_LOG_TRANSITION, trans);
		write_reg(REG_LOG_EMISSION_AT, at);
		write_reg(REG_LOG_EMISSION_GC, gc);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Same value in every lane of a register
	function automatic logic [63:0] fill_lanes(input logic [15:0] v);
		return {4{v}};
	endfunction

	// Lane mix: log zero, both rails, zero, plausible log probabilities, raw noise
	function automatic logic [15:0] random_lane();
		case ($urandom_range(0, 7))
			0:       return LOG_ZERO_RAW;
			1:       return MOST_POS;
			2:       return MOST_NEG;
			3:       return 16'h0000;
			4, 5:    return 16'(-$urandom_range(1, 12000));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [63:0] random_reg();
		return {random_lane(), random_lane(), random_lane(), random_lane()};
	endfunction

	task automatic program_island_model();
		program_hmm({LN_0P5, LN_0P5},
			{LN_0P51, LN_0P49, LN_0P49, LN_0P51},
			{LN_0P3, LN_0P3, LN_0P2, LN_0P2},
			{LN_0P2, LN_0P2, LN_0P3, LN_0P3});
	endtask

	// Mostly well-formed sequences; the rest is loose beats with random markers
	task automatic random_sequence();
		int len;
		if ($urandom_range(0, 9) < 8) begin
			len = $urandom_range(1, 24);
			for (int i = 0; i < len; i++)
				send_base(2'($urandom), i == 0, i == len - 1);
		end else begin
			len = $urandom_range(1, 6);
			for (int i = 0; i < len; i++)
				send_base(2'($urandom), $urandom_range(0, 3) == 0, 1'($urandom));
		end
	endtask

	initial begin
		int next_reprogram;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		program_island_model();
		// No first since reset: the states are still log zero
		send_base(BASE_G, 1'b0, 1'b1);
		// First and last on the same beat, every base
		send_base(BASE_G, 1'b1, 1'b1);
		send_base(BASE_C, 1'b1, 1'b1);
		send_base(BASE_A, 1'b1, 1'b1);
		send_base(BASE_T, 1'b1, 1'b1);
		send_base(BASE_A, 1'b1, 1'b0);
		send_base(BASE_C, 1'b0, 1'b0);
		send_base(BASE_G, 1'b0, 1'b0);
		send_base(BASE_T, 1'b0, 1'b1);
		drain();

		// Widest state gap: the correction index reaches the last table entry
		program_hmm({MOST_NEG, 16'h0000}, '0, '0, '0);
		send_base(BASE_T, 1'b1, 1'b1);
		drain();

		// One state starts at log zero, so the log-sum passes the other through
		program_hmm({LOG_ZERO_RAW, LN_0P5}, fill_lanes(LN_0P49), fill_lanes(LN_0P3),
			fill_lanes(LN_0P2));
		send_base(BASE_C, 1'b1, 1'b0);
		send_base(BASE_A, 1'b0, 1'b1);
		drain();

		// Every transition is log zero: the recursion kills both paths
		program_hmm({LN_0P5, LN_0P5}, fill_lanes(LOG_ZERO_RAW), fill_lanes(LN_0P2),
			fill_lanes(LN_0P3));
		send_base(BASE_G, 1'b1, 1'b0);
		send_base(BASE_T, 1'b0, 1'b1);
		drain();

		program_hmm({2{LOG_ZERO_RAW}}, fill_lanes(LOG_ZERO_RAW), fill_lanes(LOG_ZERO_RAW),
			fill_lanes(LOG_ZERO_RAW));
		send_base(BASE_A, 1'b1, 1'b0);
		send_base(BASE_A, 1'b0, 1'b1);
		drain();

		program_hmm({2{MOST_POS}}, fill_lanes(MOST_POS), fill_lanes(MOST_POS),
			fill_lanes(MOST_POS));
		send_base(BASE_G, 1'b1, 1'b0);
		send_base(BASE_C, 1'b0, 1'b0);
		send_base(BASE_T, 1'b0, 1'b1);
		drain();

		program_hmm('0, '0, '0, '0);
		send_base(BASE_T, 1'b1, 1'b0);
		send_base(BASE_A, 1'b0, 1'b0);
		send_base(BASE_G, 1'b0, 1'b1);
		drain();

		// Random part: reprogram every few hundred bases, mixing in the island model
		bases_sent     = 0;
		next_reprogram = 0;
		while (bases_sent < RANDOM_BASES) begin
			if (bases_sent >= next_reprogram) begin
				drain();
				if ($urandom_range(0, 3) == 0)
					program_island_model();
				else
					program_hmm(random_reg(), random_reg(), random_reg(), random_reg());
				next_reprogram = bases_sent + $urandom_range(100, 300);
			end
			quiet = $urandom_range(0, 4) == 0;
			// Now and then hold the sender until every pending beat is out
			if ($urandom_range(0, 29) == 0)
				drain();
			random_sequence();
		end

		@(negedge clk);
		item_valid <= 1'b0;
		wait (pending == 0);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
